>>> sv/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

	// Field widths
	localparam int REQ_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 4;
	localparam int INDEX_W = 11;
	localparam int LOC_W   = 11;
	localparam int CELL_W  = 16;

	// Default geometry
	localparam int DEF_COLUMNS   = 80;
	localparam int DEF_ROWS      = 25;
	localparam int DEF_TAB_WIDTH = 8;

	// Blank cell: white on black space
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

	// Command from sequencer to cursor unit
	typedef struct packed {
		logic              put;
		logic              home;
		logic [CHAR_W-1:0] char_code;
	} tcw_cur_cmd_t;

	// Status from cursor unit
	typedef struct packed {
		logic scroll;
		logic printable;
	} tcw_cur_sts_t;

	function automatic logic is_printable(input logic [CHAR_W-1:0] ch);
		return (ch >= CH_PRINT_LO) && (ch <= CH_PRINT_HI);
	endfunction

endpackage

>>> sv/tcw_store.sv
`timescale 1ns / 1ps

module tcw_store #(
	parameter int CELL_N = 2000,
	parameter int ADDR_W = 11
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [tcw_pkg::CELL_W-1:0] wdata,
	input  logic [ADDR_W-1:0]          raddr,
	output logic [tcw_pkg::CELL_W-1:0] rdata
);
	import tcw_pkg::*;

	logic [CELL_W-1:0] mem_q [CELL_N];
	logic [CELL_W-1:0] rdata_q;

	// One write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// One registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/tcw_cursor.sv
`timescale 1ns / 1ps

module tcw_cursor #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8,
	parameter int ADDR_W    = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tcw_pkg::tcw_cur_cmd_t     cmd,
	output tcw_pkg::tcw_cur_sts_t     sts,
	output logic [ADDR_W-1:0]         cur_pos,
	output logic [tcw_pkg::LOC_W-1:0] cur_loc,
	output logic [tcw_pkg::LOC_W-1:0] nxt_loc
);
	import tcw_pkg::*;

	localparam int CW = $clog2(COLUMNS + TAB_WIDTH);
	localparam int RW = $clog2(ROWS + 1);
	localparam int PW = $clog2(TAB_WIDTH);

	logic [CW-1:0] col_q, col_n, col_t;
	logic [RW-1:0] row_q, row_n, row_t;
	logic [PW-1:0] ph_q, ph_n, ph_t;   // column modulo tab width
	logic          scroll;
	logic [ADDR_W-1:0] nxt_pos;

	// Next cursor position for a put
	always_comb begin
		col_t  = col_q;
		row_t  = row_q;
		ph_t   = ph_q;
		scroll = 1'b0;
		if (cmd.char_code == CH_BS) begin
			if (col_q != '0) begin
				col_t = col_q - CW'(1);
				ph_t  = (ph_q == '0) ? PW'(TAB_WIDTH - 1) : ph_q - PW'(1);
			end
		end else if (cmd.char_code == CH_TAB) begin
			col_t = col_q + CW'(TAB_WIDTH) - CW'(ph_q);
			ph_t  = '0;
		end else if (cmd.char_code == CH_CR) begin
			col_t = '0;
			ph_t  = '0;
		end else if (cmd.char_code == CH_LF) begin
			col_t = '0;
			ph_t  = '0;
			row_t = row_q + RW'(1);
		end else if (is_printable(cmd.char_code)) begin
			col_t = col_q + CW'(1);
			ph_t  = (ph_q == PW'(TAB_WIDTH - 1)) ? '0 : ph_q + PW'(1);
		end
		// line wrap
		if (col_t >= CW'(COLUMNS)) begin
			col_t = '0;
			ph_t  = '0;
			row_t = row_t + RW'(1);
		end
		// past the last row
		if (row_t >= RW'(ROWS)) begin
			row_t  = RW'(ROWS - 1);
			scroll = 1'b1;
		end
	end

	always_comb begin
		col_n = col_q;
		row_n = row_q;
		ph_n  = ph_q;
		if (cmd.home) begin
			col_n = '0;
			row_n = '0;
			ph_n  = '0;
		end else if (cmd.put) begin
			col_n = col_t;
			row_n = row_t;
			ph_n  = ph_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ph_q  <= '0;
		end else begin
			col_q <= col_n;
			row_q <= row_n;
			ph_q  <= ph_n;
		end
	end

	// Linear positions
	assign cur_pos = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign nxt_pos = ADDR_W'(row_n) * ADDR_W'(COLUMNS) + ADDR_W'(col_n);
	assign cur_loc = LOC_W'(cur_pos);
	assign nxt_loc = LOC_W'(nxt_pos);

	assign sts.scroll    = cmd.put && scroll;
	assign sts.printable = is_printable(cmd.char_code);

endmodule

>>> sv/text_console_writer_top.sv
`timescale 1ns / 1ps

// Put of a character or control code without scroll: result is registered on accept.
// Read: through ST_READ, then the result is registered. Clear: ST_CLEAR blanks every cell.
// Put that scrolls: a copy sweep moves each row up through the separate read and write ports of
// the cell memory (one cell per cycle), then the last row is blanked. Input stalls outside idle
// (a read, clear or sweep) or while a result waits. Reset: cursor homes at once; a clearing pass
// then blanks the store, and no item is accepted until it finishes.
module text_console_writer_top #(
	parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS      = tcw_pkg::DEF_ROWS,
	parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tcw_pkg::REQ_W-1:0]   req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::COLOR_W-1:0] bg_color,
	input  logic [tcw_pkg::COLOR_W-1:0] fg_color,
	input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tcw_pkg::LOC_W-1:0]   cursor_location,
	output logic [tcw_pkg::CELL_W-1:0]  cell_data
);
	import tcw_pkg::*;

	localparam int CELL_N = COLUMNS * ROWS;
	localparam int COPY_N = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W = $clog2(CELL_N);

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_READ   = 6'b000100,
		ST_CLEAR  = 6'b001000,
		ST_SCROLL = 6'b010000,
		ST_BLANK  = 6'b100000
	} tcw_state_t;

	tcw_state_t        state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] dst_q;
	logic              pend_q;
	logic              oor_q;
	logic              out_valid_q;
	logic [LOC_W-1:0]  loc_q;
	logic [CELL_W-1:0] data_q;

	logic              accept;
	logic              oor;
	tcw_cur_cmd_t      cmd;
	tcw_cur_sts_t      sts;
	logic [ADDR_W-1:0] cur_pos;
	logic [LOC_W-1:0]  cur_loc;
	logic [LOC_W-1:0]  nxt_loc;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic [ADDR_W-1:0] raddr;
	logic [CELL_W-1:0] rdata;

	// Input handshake
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign oor      = 32'(cell_index) >= 32'(CELL_N);

	assign cmd.put       = accept && (req_type == REQ_PUT);
	assign cmd.home      = accept && (req_type == REQ_CLEAR);
	assign cmd.char_code = char_code;

	tcw_cursor #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_WIDTH(TAB_WIDTH),
		.ADDR_W   (ADDR_W)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.cur_pos(cur_pos),
		.cur_loc(cur_loc),
		.nxt_loc(nxt_loc)
	);

	// Memory port steering
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = BLANK_CELL;
		raddr = oor ? '0 : ADDR_W'(cell_index);
		unique case (state_q)
			ST_INIT, ST_CLEAR, ST_BLANK: begin
				we = 1'b1;
			end
			ST_IDLE: begin
				we    = cmd.put && sts.printable;
				waddr = cur_pos;
				wdata = {bg_color, fg_color, char_code};
			end
			ST_SCROLL: begin
				we    = pend_q;
				waddr = dst_q;
				wdata = rdata;
				raddr = cnt_q + ADDR_W'(COLUMNS);
			end
			ST_READ: begin
				we = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	tcw_store #(
		.CELL_N(CELL_N),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Sequencer; a result only waits in the idle state, sweeps start with it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == ADDR_W'(CELL_N - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_PUT: begin
								if (sts.scroll) begin
									cnt_q       <= '0;
									pend_q      <= 1'b0;
									out_valid_q <= 1'b0;
									state_q     <= ST_SCROLL;
								end else begin
									out_valid_q <= 1'b1;
								end
							end
							REQ_CLEAR: begin
								cnt_q       <= '0;
								out_valid_q <= 1'b0;
								state_q     <= ST_CLEAR;
							end
							REQ_READ: begin
								out_valid_q <= 1'b0;
								state_q     <= ST_READ;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end else if (!out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == ADDR_W'(CELL_N - 1)) begin
						cnt_q       <= '0;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_SCROLL: begin
					pend_q <= (cnt_q != ADDR_W'(COPY_N));
					if (cnt_q == ADDR_W'(COPY_N)) begin
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				ST_BLANK: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == ADDR_W'(CELL_N - 1)) begin
						cnt_q       <= '0;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		dst_q <= cnt_q;
		if (accept) begin
			oor_q  <= oor;
			loc_q  <= nxt_loc;
			data_q <= '0;
		end
		if (state_q == ST_READ) begin
			loc_q  <= cur_loc;
			data_q <= oor_q ? '0 : rdata;
		end
		if (state_q == ST_CLEAR || state_q == ST_BLANK) begin
			loc_q  <= cur_loc;
			data_q <= '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_location = loc_q;
	assign cell_data       = data_q;

endmodule
